/* hw/rtl/message_result_cache_macros.svh */
// Assertion macros shared by the message result cache RTL.
`ifndef MESSAGE_RESULT_CACHE_MACROS_SVH
`define MESSAGE_RESULT_CACHE_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define MRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define MRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/mrc_pkg.sv */
// Types, codes and defaults shared by the message result cache modules.
package mrc_pkg;

    localparam int NUM_ENTRIES_DEF = 32;
    localparam int STORE_BYTES_DEF = 16;
    localparam int HASH_BITS_DEF   = 128;
    localparam int IDX_MAX_W       = 10;
    localparam int KEY_W           = 128;

    localparam logic [7:0] MODE_FREE   = 8'h00;
    localparam logic [5:0] CNT_FIRST   = 6'h01;
    localparam logic [5:0] CNT_LAST    = 6'h3D;
    localparam logic [5:0] CNT_PERM    = 6'h3E;
    localparam logic [5:0] CNT_GOOD    = 6'h3F;
    localparam logic [7:0] MODE_QUEUED = 8'h40;
    localparam logic [7:0] MODE_WAIT   = 8'h80;
    localparam logic [5:0] MAX_FAIL_RST = 6'd2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_REPORT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_NEW     = 4'd0,
        ST_RETRY   = 4'd1,
        ST_HIT     = 4'd2,
        ST_PERM    = 4'd3,
        ST_BUSY    = 4'd4,
        ST_REC_OK  = 4'd5,
        ST_REC_BAD = 4'd6,
        ST_BAD_ID  = 4'd7,
        ST_CLEARED = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MISS,
        S_REPORT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic                 load;
        logic [IDX_MAX_W-1:0] load_idx;
        logic                 shift;
        logic                 clear;
        logic                 we_hash;
        logic                 we_mode;
        logic                 we_pay;
        logic [KEY_W-1:0]     hash;
        logic [7:0]           mode;
        logic [127:0]         pay;
    } t_cell_cmd;

    typedef struct packed {
        logic         free;
        logic         match;
        logic [7:0]   mode;
        logic [127:0] pay;
    } t_cell_rsp;

    typedef struct packed {
        t_status     status;
        logic [5:0]  queue_id;
        logic [5:0]  fail_count;
        logic [63:0] pay_hi;
        logic [63:0] pay_lo;
        logic        wake;
    } t_result;

endpackage

/* hw/rtl/mrc_cell.sv */
// One cache slot of the ring: hash, mode and payload, plus the walking search token.
module mrc_cell #(
    parameter int IDX       = 0,
    parameter int HASH_BITS = mrc_pkg::HASH_BITS_DEF,
    parameter int PAY_W     = 8 * mrc_pkg::STORE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mrc_pkg::t_cell_cmd i_cmd,
    input  logic               i_tok,
    output logic               o_tok,
    output mrc_pkg::t_cell_rsp o_rsp
);

    logic                 r_tok;
    logic                 n_tok;
    logic [7:0]           r_mode;
    logic [HASH_BITS-1:0] r_hash;
    logic [PAY_W-1:0]     r_pay;

    always_comb begin
        if (i_cmd.load) begin
            n_tok = (i_cmd.load_idx == mrc_pkg::IDX_MAX_W'(IDX));
        end else if (i_cmd.shift) begin
            n_tok = i_tok;
        end else begin
            n_tok = r_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_mode <= mrc_pkg::MODE_FREE;
        end else begin
            r_tok <= n_tok;
            if (i_cmd.clear) begin
                r_mode <= mrc_pkg::MODE_FREE;
            end else if (r_tok && i_cmd.we_mode) begin
                r_mode <= i_cmd.mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_hash <= '0;
        end else if (r_tok && i_cmd.we_hash) begin
            r_hash <= i_cmd.hash[HASH_BITS-1:0];
        end
        if (r_tok && i_cmd.we_pay) begin
            r_pay <= i_cmd.pay[PAY_W-1:0];
        end
    end

    assign o_tok = r_tok;

    always_comb begin
        o_rsp       = '0;
        o_rsp.free  = r_tok && (r_mode == mrc_pkg::MODE_FREE);
        o_rsp.match = r_tok && (r_hash == i_cmd.hash[HASH_BITS-1:0]);
        o_rsp.mode  = r_tok ? r_mode : 8'h00;
        o_rsp.pay   = r_tok ? 128'(r_pay) : 128'h0;
    end

endmodule

/* hw/rtl/message_result_cache.sv */
// Top level of the message result cache: ring of slot cells and the operation sequencer.
// The cache holds NUM_ENTRIES slots, each a cell in a ring through which a search token
// walks one slot per cycle. A lookup walks that token backward from the ring pointer
// until it stops at a free slot, a hash match or the last unchecked slot, passing through
// S_MISS when no match is found before S_RESP; a report goes through S_REPORT (straight
// to S_RESP for a bad id) and a clear straight to S_RESP. One item is processed at a time,
// and a result held in the output register is not overwritten until it is taken. No
// clearing pass is needed after reset.
`include "message_result_cache_macros.svh"
module message_result_cache #(
    parameter int NUM_ENTRIES = mrc_pkg::NUM_ENTRIES_DEF,
    parameter int STORE_BYTES = mrc_pkg::STORE_BYTES_DEF,
    parameter int HASH_BITS   = mrc_pkg::HASH_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // hash_hi, hash_lo, entry_id, result_good, payload_in_hi, payload_in_lo, zero pad
    input  logic [263:0] i_s_tdata,
    // operation
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // queue_id, fail_count, payload_out_hi, payload_out_lo, wake_waiters, zero pad
    output logic [143:0] o_m_tdata,
    // status
    output logic [3:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [5:0]   i_cfg_data
);

    localparam int IW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int PAY_W = (STORE_BYTES > 0) ? 8 * STORE_BYTES : 1;
    localparam logic [IW-1:0] LAST = IW'(NUM_ENTRIES - 1);

    mrc_pkg::t_state    r_state, n_state;
    mrc_pkg::t_cell_cmd w_cmd;
    mrc_pkg::t_cell_rsp w_cell_rsp [NUM_ENTRIES];
    mrc_pkg::t_cell_rsp w_rsp;
    logic [NUM_ENTRIES-1:0] w_tok;

    logic [IW-1:0]  r_rp, n_rp;
    logic [IW-1:0]  r_cur, n_cur;
    logic [IW-1:0]  r_cnt, n_cnt;
    logic [127:0]   r_key, n_key;
    logic [127:0]   r_pay, n_pay;
    logic           r_good, n_good;
    logic [5:0]     r_max_fail;
    mrc_pkg::t_result r_res, n_res;
    mrc_pkg::t_result r_out, n_out;
    logic           r_ovalid, n_ovalid;

    logic          w_acc;
    mrc_pkg::t_op  w_op;
    logic [5:0]    w_id;
    logic [31:0]   w_id_m1;
    logic [5:0]    w_cnt6;
    logic [31:0]   w_qid;

    genvar g;
    generate
        for (g = 0; g < NUM_ENTRIES; g++) begin : g_cell
            mrc_cell #(
                .IDX       (g),
                .HASH_BITS (HASH_BITS),
                .PAY_W     (PAY_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_tok   (w_tok[(g + 1) % NUM_ENTRIES]),
                .o_tok   (w_tok[g]),
                .o_rsp   (w_cell_rsp[g])
            );
        end
    endgenerate

    always_comb begin
        w_rsp = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            w_rsp = mrc_pkg::t_cell_rsp'(w_rsp | w_cell_rsp[i]);
        end
    end

    assign o_s_tready  = (r_state == mrc_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc   = i_s_tvalid && o_s_tready;
    assign w_op    = mrc_pkg::t_op'(i_s_tuser);
    assign w_id    = i_s_tdata[133:128];
    assign w_id_m1 = 32'(w_id) - 32'd1;

    always_comb begin
        n_state  = r_state;
        n_rp     = r_rp;
        n_cur    = r_cur;
        n_cnt    = r_cnt;
        n_key    = r_key;
        n_pay    = r_pay;
        n_good   = r_good;
        n_res    = r_res;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_m_tready;
        w_cmd      = '0;
        w_cmd.hash = r_key;
        w_cmd.pay  = (STORE_BYTES > 0) ? r_pay : 128'h0;
        w_cnt6     = 6'h00;
        w_qid      = 32'(r_cur) + 32'd1;
        unique case (r_state)
            mrc_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_key  = {i_s_tdata[63:0], i_s_tdata[127:64]};
                    n_good = i_s_tdata[134];
                    n_pay  = {i_s_tdata[198:135], i_s_tdata[262:199]};
                    n_res  = '0;
                    unique case (w_op)
                        mrc_pkg::OP_LOOKUP: begin
                            w_cmd.load     = 1'b1;
                            n_cur          = (r_rp == '0) ? LAST : r_rp - 1'b1;
                            w_cmd.load_idx = mrc_pkg::IDX_MAX_W'(n_cur);
                            n_cnt          = '0;
                            n_state        = mrc_pkg::S_SEARCH;
                        end
                        mrc_pkg::OP_REPORT: begin
                            if (w_id == 6'd0 || 32'(w_id) > NUM_ENTRIES) begin
                                n_res.status = mrc_pkg::ST_BAD_ID;
                                n_state      = mrc_pkg::S_RESP;
                            end else begin
                                w_cmd.load     = 1'b1;
                                w_cmd.load_idx = mrc_pkg::IDX_MAX_W'(w_id_m1[IW-1:0]);
                                n_state        = mrc_pkg::S_REPORT;
                            end
                        end
                        mrc_pkg::OP_CLEAR: begin
                            w_cmd.clear  = 1'b1;
                            n_rp         = '0;
                            n_res.status = mrc_pkg::ST_CLEARED;
                            n_state      = mrc_pkg::S_RESP;
                        end
                        default: begin
                            n_state = mrc_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            mrc_pkg::S_SEARCH: begin
                priority if (w_rsp.free || (!w_rsp.match && r_cnt == LAST)) begin
                    w_cmd.load     = 1'b1;
                    w_cmd.load_idx = mrc_pkg::IDX_MAX_W'(r_rp);
                    n_state        = mrc_pkg::S_MISS;
                end else if (w_rsp.match) begin
                    n_state = mrc_pkg::S_RESP;
                    priority if ((w_rsp.mode & mrc_pkg::MODE_QUEUED) != 8'h00) begin
                        w_cmd.we_mode = 1'b1;
                        w_cmd.mode    = w_rsp.mode | mrc_pkg::MODE_WAIT;
                        n_res.status  = mrc_pkg::ST_BUSY;
                    end else if (w_rsp.mode == {2'b00, mrc_pkg::CNT_GOOD}) begin
                        n_res.status   = mrc_pkg::ST_HIT;
                        n_res.queue_id = w_qid[5:0];
                        n_res.pay_hi   = w_rsp.pay[127:64];
                        n_res.pay_lo   = w_rsp.pay[63:0];
                    end else if (w_rsp.mode >= {2'b00, mrc_pkg::CNT_FIRST} &&
                                 w_rsp.mode <= {2'b00, mrc_pkg::CNT_LAST}) begin
                        w_cmd.we_mode  = 1'b1;
                        w_cmd.mode     = w_rsp.mode | mrc_pkg::MODE_QUEUED;
                        n_res.status   = mrc_pkg::ST_RETRY;
                        n_res.queue_id = w_qid[5:0];
                    end else begin
                        n_res.status = mrc_pkg::ST_PERM;
                    end
                end else begin
                    w_cmd.shift = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    n_cur       = (r_cur == '0) ? LAST : r_cur - 1'b1;
                end
            end
            mrc_pkg::S_MISS: begin
                w_cmd.we_mode = 1'b1;
                n_state       = mrc_pkg::S_RESP;
                if ((w_rsp.mode & mrc_pkg::MODE_QUEUED) != 8'h00) begin
                    w_cmd.mode   = w_rsp.mode | mrc_pkg::MODE_WAIT;
                    n_res.status = mrc_pkg::ST_BUSY;
                end else begin
                    w_qid          = 32'(r_rp) + 32'd1;
                    w_cmd.we_hash  = 1'b1;
                    w_cmd.mode     = mrc_pkg::MODE_QUEUED;
                    n_res.status   = mrc_pkg::ST_NEW;
                    n_res.queue_id = w_qid[5:0];
                    n_rp           = (r_rp == LAST) ? '0 : r_rp + 1'b1;
                end
            end
            mrc_pkg::S_REPORT: begin
                w_cmd.we_mode = 1'b1;
                n_res.wake    = w_rsp.mode[7];
                n_state       = mrc_pkg::S_RESP;
                if (r_good) begin
                    w_cmd.we_pay = 1'b1;
                    w_cmd.mode   = {2'b00, mrc_pkg::CNT_GOOD};
                    n_res.status = mrc_pkg::ST_REC_OK;
                end else begin
                    w_cnt6 = (w_rsp.mode[5:0] == mrc_pkg::CNT_GOOD) ? 6'h00 : w_rsp.mode[5:0];
                    if (w_cnt6 <= mrc_pkg::CNT_LAST) begin
                        w_cnt6 = w_cnt6 + 6'd1;
                        if (w_cnt6 >= r_max_fail) begin
                            w_cnt6 = mrc_pkg::CNT_PERM;
                        end
                    end else begin
                        w_cnt6 = mrc_pkg::CNT_PERM;
                    end
                    w_cmd.mode       = {2'b00, w_cnt6};
                    n_res.status     = mrc_pkg::ST_REC_BAD;
                    n_res.fail_count = w_cnt6;
                end
            end
            mrc_pkg::S_RESP: begin
                if (!r_ovalid || i_m_tready) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = mrc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mrc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mrc_pkg::S_IDLE;
            r_rp       <= '0;
            r_cur      <= '0;
            r_cnt      <= '0;
            r_ovalid   <= 1'b0;
            r_max_fail <= mrc_pkg::MAX_FAIL_RST;
        end else begin
            r_state  <= n_state;
            r_rp     <= n_rp;
            r_cur    <= n_cur;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_fail <= (i_cfg_data > mrc_pkg::CNT_PERM) ? mrc_pkg::CNT_PERM : i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_pay  <= n_pay;
        r_good <= n_good;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {3'b000, r_out.wake, r_out.pay_lo, r_out.pay_hi,
                         r_out.fail_count, r_out.queue_id};

    `MRC_ASSERT(a_tok_onehot0, $onehot0(w_tok), "more than one search token in the ring")
    `MRC_ASSERT(a_tok_search, (r_state == mrc_pkg::S_SEARCH) |-> $onehot(w_tok), "no token")
    `MRC_ASSERT(a_rp_range, r_rp <= LAST, "ring pointer out of range")
    `MRC_ASSERT(a_clear_rp, (w_acc && w_op == mrc_pkg::OP_CLEAR) |=> (r_rp == '0), "pointer kept")

endmodule
